/* rtl/core/tos_pkg.sv */
// types, option codes and helpers shared by the tcp option serializer
`default_nettype none
package tos_pkg;

	localparam int IN_DATA_W  = 160;
	localparam int OUT_DATA_W = 16;

	localparam logic [7:0] KIND_EOL     = 8'd0;
	localparam logic [7:0] KIND_NOP     = 8'd1;
	localparam logic [7:0] KIND_MSS     = 8'd2;
	localparam logic [7:0] KIND_WSCALE  = 8'd3;
	localparam logic [7:0] KIND_SACK_OK = 8'd4;
	localparam logic [7:0] KIND_SACK    = 8'd5;
	localparam logic [7:0] KIND_TS      = 8'd8;
	localparam logic [7:0] LEN_MSS      = 8'd4;
	localparam logic [7:0] LEN_WSCALE   = 8'd3;
	localparam logic [7:0] LEN_SACK_OK  = 8'd2;
	localparam logic [7:0] LEN_TS       = 8'd10;

	localparam logic [3:0] LAST_SUB_MSS  = 4'd3;
	localparam logic [3:0] LAST_SUB_WS   = 4'd2;
	localparam logic [3:0] LAST_SUB_SOK  = 4'd1;
	localparam logic [3:0] LAST_SUB_TS   = 4'd9;
	localparam logic [3:0] LAST_SUB_SACK = 4'd1;
	localparam logic [3:0] LAST_SUB_BLK  = 4'd7;

	localparam logic OP_HEADER = 1'b0;
	localparam logic OP_BLOCK  = 1'b1;

	typedef enum logic [6:0] {
		SEG_MSS  = 7'b0000001,
		SEG_WS   = 7'b0000010,
		SEG_SOK  = 7'b0000100,
		SEG_TS   = 7'b0001000,
		SEG_SACK = 7'b0010000,
		SEG_BLK  = 7'b0100000,
		SEG_PAD  = 7'b1000000
	} seg_t;

	typedef struct packed {
		logic [7:0] option_byte;
		logic       last_byte;
		logic [5:0] options_length;
	} result_t;

	function automatic logic [7:0] be_byte(input logic [31:0] word, input logic [1:0] idx);
		logic [7:0] b;
		b = word[31 - 8 * idx -: 8];
		return b;
	endfunction

endpackage
`default_nettype wire

/* rtl/core/tos_seq.sv */
// item register and byte sequencer of the tcp option serializer
`default_nettype none
module tos_seq #(
	parameter int MAX_SACK_BLOCKS = 3
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	input  wire logic                         s_tuser,
	input  wire logic [tos_pkg::IN_DATA_W-1:0] s_tdata,
	output logic                              res_valid,
	input  wire logic                         res_ready,
	output tos_pkg::result_t                  res
);
	import tos_pkg::*;

	logic        in_mss_p, in_ws_p, in_sok_p, in_ts_p;
	logic [15:0] in_mss;
	logic [7:0]  in_ws;
	logic [31:0] in_tsv, in_tse, in_bstart, in_bend;
	logic [2:0]  in_count, n_sat;

	logic [5:0]  flag_q;
	logic        pad_q, pad_first_q;
	logic [3:0]  sub_q;
	logic [5:0]  len_q;
	logic [2:0]  pend_q, sackn_q;
	logic [15:0] mss_q;
	logic [7:0]  ws_q;
	logic [31:0] tsv_q, tse_q, bstart_q, bend_q;

	logic [5:0]  cur_flag;
	logic        flag_none;
	seg_t        cur_seg;
	logic        active, seg_done, final_byte, emit, accept;
	logic [5:0]  new_len;
	logic [7:0]  byte_val;

	assign in_mss_p  = s_tdata[0];
	assign in_ws_p   = s_tdata[1];
	assign in_sok_p  = s_tdata[2];
	assign in_ts_p   = s_tdata[3];
	assign in_mss    = s_tdata[19:4];
	assign in_ws     = s_tdata[27:20];
	assign in_tsv    = s_tdata[59:28];
	assign in_tse    = s_tdata[91:60];
	assign in_count  = s_tdata[94:92];
	assign in_bstart = s_tdata[126:95];
	assign in_bend   = s_tdata[158:127];

	assign n_sat = (in_count > 3'(MAX_SACK_BLOCKS)) ? 3'(MAX_SACK_BLOCKS) : in_count;

	// lowest set flag is the option being sent, padding once none are left
	assign cur_flag  = flag_q & (~flag_q + 6'd1);
	assign flag_none = (flag_q == 6'd0);
	assign cur_seg   = seg_t'({flag_none, cur_flag});
	assign new_len   = len_q + 6'd1;
	assign active    = !flag_none || (pad_q && (len_q[1:0] != 2'b00));

	always_comb begin
		seg_done = 1'b0;
		byte_val = KIND_NOP;
		unique case (cur_seg)
			SEG_MSS: begin
				seg_done = (sub_q == LAST_SUB_MSS);
				byte_val = (sub_q == 4'd0) ? KIND_MSS :
				           (sub_q == 4'd1) ? LEN_MSS :
				           (sub_q == 4'd2) ? mss_q[15:8] : mss_q[7:0];
			end
			SEG_WS: begin
				seg_done = (sub_q == LAST_SUB_WS);
				byte_val = (sub_q == 4'd0) ? KIND_WSCALE :
				           (sub_q == 4'd1) ? LEN_WSCALE : ws_q;
			end
			SEG_SOK: begin
				seg_done = (sub_q == LAST_SUB_SOK);
				byte_val = (sub_q == 4'd0) ? KIND_SACK_OK : LEN_SACK_OK;
			end
			SEG_TS: begin
				seg_done = (sub_q == LAST_SUB_TS);
				if (sub_q == 4'd0) begin
					byte_val = KIND_TS;
				end else if (sub_q == 4'd1) begin
					byte_val = LEN_TS;
				end else if (sub_q < 4'd6) begin
					byte_val = be_byte(tsv_q, 2'(sub_q - 4'd2));
				end else begin
					byte_val = be_byte(tse_q, 2'(sub_q - 4'd6));
				end
			end
			SEG_SACK: begin
				seg_done = (sub_q == LAST_SUB_SACK);
				byte_val = (sub_q == 4'd0) ? KIND_SACK : {2'b00, sackn_q, 3'b010};
			end
			SEG_BLK: begin
				seg_done = (sub_q == LAST_SUB_BLK);
				byte_val = sub_q[2] ? be_byte(bend_q, sub_q[1:0]) : be_byte(bstart_q, sub_q[1:0]);
			end
			SEG_PAD: begin
				seg_done = 1'b0;
				byte_val = pad_first_q ? KIND_EOL : KIND_NOP;
			end
			default: begin
				seg_done = 1'b0;
				byte_val = KIND_NOP;
			end
		endcase
	end

	assign final_byte = (flag_none || (seg_done && ((flag_q & ~cur_flag) == 6'd0)))
	                    && (!pad_q || (new_len[1:0] == 2'b00));

	assign emit      = active && res_ready;
	assign s_tready  = !active || (res_ready && final_byte);
	assign accept    = s_tvalid && s_tready;
	assign res_valid = active;

	assign res.option_byte    = byte_val;
	assign res.last_byte      = final_byte && pad_q;
	assign res.options_length = new_len;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q      <= 6'd0;
			pad_q       <= 1'b0;
			pad_first_q <= 1'b0;
			sub_q       <= 4'd0;
			len_q       <= 6'd0;
			pend_q      <= 3'd0;
			sackn_q     <= 3'd0;
		end else if (accept) begin
			sub_q       <= 4'd0;
			pad_first_q <= 1'b1;
			if (s_tuser == OP_HEADER) begin
				flag_q  <= {1'b0, n_sat != 3'd0, in_ts_p, in_sok_p, in_ws_p, in_mss_p};
				pad_q   <= (n_sat == 3'd0);
				pend_q  <= n_sat;
				sackn_q <= n_sat;
				len_q   <= 6'd0;
			end else begin
				len_q <= emit ? new_len : len_q;
				if (pend_q != 3'd0) begin
					flag_q <= 6'b100000;
					pad_q  <= (pend_q == 3'd1);
					pend_q <= pend_q - 3'd1;
				end else begin
					flag_q <= 6'd0;
					pad_q  <= 1'b0;
				end
			end
		end else if (emit) begin
			len_q <= new_len;
			if (cur_seg == SEG_PAD) begin
				pad_first_q <= 1'b0;
			end else if (seg_done) begin
				flag_q <= flag_q & ~cur_flag;
				sub_q  <= 4'd0;
			end else begin
				sub_q <= sub_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mss_q    <= in_mss;
			ws_q     <= in_ws;
			tsv_q    <= in_tsv;
			tse_q    <= in_tse;
			bstart_q <= in_bstart;
			bend_q   <= in_bend;
		end
	end

endmodule
`default_nettype wire

/* rtl/core/tos_out.sv */
// output register of the tcp option serializer
`default_nettype none
module tos_out (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire tos_pkg::result_t              in_res,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [tos_pkg::OUT_DATA_W-1:0]     m_tdata,
	output logic                               m_tlast
);
	import tos_pkg::*;

	logic    valid_q;
	result_t res_q;

	assign in_ready = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			res_q <= in_res;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {2'b00, res_q.options_length, res_q.option_byte};
	assign m_tlast  = res_q.last_byte;

endmodule
`default_nettype wire

/* rtl/core/tcp_option_serializer.sv */
// top level of the tcp option serializer
//
// channel  dir  fields
// s_*      in   tuser: operation; tdata: option set header or sack block item
// m_*      out  tdata: option byte and running length; tlast: final byte of area
//
// one output byte per cycle from the byte sequencer while m_tready does not stall it
// s_tready is high while the sequencer is idle or sends an item's final byte
// arst_n clears pending blocks, running length and the output register
// a low m_tready holds the output byte and stalls the sequencer
`default_nettype none
module tcp_option_serializer #(
	parameter int MAX_SACK_BLOCKS = 3
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// operation
	input  wire logic                           s_tuser,
	// mss_present, wscale_present, sack_permitted_present, timestamp_present,
	// mss_value, wscale_value, ts_value, ts_echo, sack_count, block_start, block_end
	input  wire logic [tos_pkg::IN_DATA_W-1:0]  s_tdata,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// option_byte, options_length
	output logic [tos_pkg::OUT_DATA_W-1:0]      m_tdata,
	// last_byte
	output logic                                m_tlast
);
	import tos_pkg::*;

	logic    res_valid, res_ready;
	result_t res;

	tos_seq #(
		.MAX_SACK_BLOCKS(MAX_SACK_BLOCKS)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	tos_out u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(res_valid),
		.in_ready(res_ready),
		.in_res  (res),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	// padded area always ends on a word boundary
	a_last_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[9:8] == 2'b00)
		else $error("option area not word aligned at last byte");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[13:8] <= 6'd56 && m_tdata[13:8] != 6'd0)
		else $error("option length out of range");

	// a byte offered by the sequencer is taken into the output register
	a_res_taken: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready |=> m_tvalid && m_tdata[7:0] == $past(res.option_byte))
		else $error("sequencer byte lost");

	a_no_accept_mid: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |-> !s_tready)
		else $error("request accepted while a byte is stalled");

endmodule
`default_nettype wire

/* verif/tb_top.sv */
// self-checking testbench for the tcp option serializer
`timescale 1ns / 1ps

typedef struct packed {
	logic        spare;
	logic [31:0] block_end;
	logic [31:0] block_start;
	logic [2:0]  sack_count;
	logic [31:0] ts_echo;
	logic [31:0] ts_value;
	logic [7:0]  wscale_value;
	logic [15:0] mss_value;
	logic        timestamp_present;
	logic        sack_permitted_present;
	logic        wscale_present;
	logic        mss_present;
} option_item_t;

class option_area_board;
	int unsigned       sack_limit;
	tos_pkg::result_t  area_bytes[$];
	logic [2:0]        blocks_left;
	logic [5:0]        area_len;
	int                step_bytes;
	int                errors;
	int                headers_seen;
	int                blocks_seen;
	int                ignored_seen;
	int                bytes_checked;
	int                areas_closed;

	function new(int unsigned limit);
		sack_limit = limit;
		blocks_left = '0;
		area_len = '0;
		step_bytes = 0;
		errors = 0;
		headers_seen = 0;
		blocks_seen = 0;
		ignored_seen = 0;
		bytes_checked = 0;
		areas_closed = 0;
	endfunction

	function void emit(logic [7:0] value);
		tos_pkg::result_t r;
		area_len = area_len + 6'd1;
		r.option_byte = value;
		r.last_byte = 1'b0;
		r.options_length = area_len;
		area_bytes.push_back(r);
		step_bytes++;
	endfunction

	function void emit_word(logic [31:0] w);
		emit(w[31:24]);
		emit(w[23:16]);
		emit(w[15:8]);
		emit(w[7:0]);
	endfunction

	function void close_area();
		tos_pkg::result_t r;
		if (area_len[1:0] != 2'd0)
			emit(tos_pkg::KIND_EOL);
		while (area_len[1:0] != 2'd0)
			emit(tos_pkg::KIND_NOP);
		if (step_bytes > 0) begin
			r = area_bytes.pop_back();
			r.last_byte = 1'b1;
			area_bytes.push_back(r);
			areas_closed++;
		end
	endfunction

	// returns 0 when the block ignores the request
	function bit note_request(logic op, option_item_t it);
		int unsigned n;
		step_bytes = 0;
		if (op == tos_pkg::OP_HEADER) begin
			headers_seen++;
			n = 32'(it.sack_count);
			if (n > sack_limit)
				n = sack_limit;
			blocks_left = '0;
			area_len = '0;
			if (it.mss_present) begin
				emit(tos_pkg::KIND_MSS);
				emit(tos_pkg::LEN_MSS);
				emit(it.mss_value[15:8]);
				emit(it.mss_value[7:0]);
			end
			if (it.wscale_present) begin
				emit(tos_pkg::KIND_WSCALE);
				emit(tos_pkg::LEN_WSCALE);
				emit(it.wscale_value);
			end
			if (it.sack_permitted_present) begin
				emit(tos_pkg::KIND_SACK_OK);
				emit(tos_pkg::LEN_SACK_OK);
			end
			if (it.timestamp_present) begin
				emit(tos_pkg::KIND_TS);
				emit(tos_pkg::LEN_TS);
				emit_word(it.ts_value);
				emit_word(it.ts_echo);
			end
			if (n != 0) begin
				emit(tos_pkg::KIND_SACK);
				emit(8'(2 + 8 * n));
				blocks_left = 3'(n);
			end else begin
				close_area();
			end
			return 1'b1;
		end
		if (blocks_left == 3'd0) begin
			ignored_seen++;
			return 1'b0;
		end
		blocks_seen++;
		emit_word(it.block_start);
		emit_word(it.block_end);
		blocks_left = blocks_left - 3'd1;
		if (blocks_left == 3'd0)
			close_area();
		return 1'b1;
	endfunction

	function void check_byte(logic [15:0] tdata, logic tlast);
		tos_pkg::result_t want;
		if (area_bytes.size() == 0) begin
			$display("%0t: unexpected byte, expected nothing, actual byte %h last %b length %0d",
				$time, tdata[7:0], tlast, tdata[13:8]);
			errors++;
			return;
		end
		want = area_bytes.pop_front();
		bytes_checked++;
		if (tdata[7:0] !== want.option_byte) begin
			$display("%0t: option_byte mismatch, expected %h actual %h",
				$time, want.option_byte, tdata[7:0]);
			errors++;
		end
		if (tlast !== want.last_byte) begin
			$display("%0t: last_byte mismatch, expected %b actual %b",
				$time, want.last_byte, tlast);
			errors++;
		end
		if (tdata[13:8] !== want.options_length) begin
			$display("%0t: options_length mismatch, expected %0d actual %0d",
				$time, want.options_length, tdata[13:8]);
			errors++;
		end
	endfunction
endclass

module tb_top;
	localparam int SACK_LIMIT = 3;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_ITEMS = 100;

	logic                           clk;
	logic                           arst_n;
	logic                           s_tvalid;
	logic                           s_tready;
	logic                           s_tuser;
	logic [tos_pkg::IN_DATA_W-1:0]  s_tdata;
	logic                           m_tvalid;
	logic                           m_tready;
	logic [tos_pkg::OUT_DATA_W-1:0] m_tdata;
	logic                           m_tlast;

	option_area_board board;
	int cycle_count;
	int burst_left;
	int stall_mode;
	int stall_hold;
	int counted;

	tcp_option_serializer #(
		.MAX_SACK_BLOCKS(SACK_LIMIT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tuser(s_tuser),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cycle_count = 0;
		stall_mode = 0;
		stall_hold = 0;
	end

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("Test completed with failures");
			$finish;
		end
	end

	// receiver: ready pattern switches between free flow, light and heavy stalls
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_byte(m_tdata, m_tlast);
		if (cycle_count % 80 == 0)
			stall_mode = $urandom_range(0, 3);
		if (stall_hold > 0) begin
			stall_hold--;
			m_tready <= 1'b0;
		end else if (stall_mode == 0) begin
			m_tready <= 1'b1;
		end else if (stall_mode == 1) begin
			m_tready <= ($urandom_range(0, 3) != 0);
		end else if (stall_mode == 2) begin
			m_tready <= 1'($urandom_range(0, 1));
		end else begin
			m_tready <= 1'b1;
			if ($urandom_range(0, 15) == 0)
				stall_hold = $urandom_range(1, 12);
		end
	end

	function automatic option_item_t scrambled_item();
		option_item_t it;
		it.spare = 1'b0;
		it.mss_present = 1'($urandom_range(0, 1));
		it.wscale_present = 1'($urandom_range(0, 1));
		it.sack_permitted_present = 1'($urandom_range(0, 1));
		it.timestamp_present = 1'($urandom_range(0, 1));
		it.mss_value = 16'($urandom);
		it.wscale_value = 8'($urandom);
		it.ts_value = $urandom;
		it.ts_echo = $urandom;
		it.sack_count = 3'($urandom_range(0, 4));
		it.block_start = $urandom;
		it.block_end = $urandom;
		return it;
	endfunction

	task automatic send_item(input logic op, input option_item_t it);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= it;
		do @(posedge clk); while (!s_tready);
		if (board.note_request(op, it))
			counted++;
		burst_left--;
		if (burst_left <= 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 10);
		end
	endtask

	task automatic send_header(input logic [3:0] flags, input logic [15:0] mss,
			input logic [7:0] ws, input logic [31:0] tsv, input logic [31:0] tse,
			input logic [2:0] cnt);
		option_item_t it;
		it = scrambled_item();
		{it.timestamp_present, it.sack_permitted_present,
			it.wscale_present, it.mss_present} = flags;
		it.mss_value = mss;
		it.wscale_value = ws;
		it.ts_value = tsv;
		it.ts_echo = tse;
		it.sack_count = cnt;
		send_item(tos_pkg::OP_HEADER, it);
	endtask

	task automatic send_block(input logic [31:0] left_edge, input logic [31:0] right_edge);
		option_item_t it;
		it = scrambled_item();
		it.block_start = left_edge;
		it.block_end = right_edge;
		send_item(tos_pkg::OP_BLOCK, it);
	endtask

	initial begin
		option_item_t it;
		int n;
		int target;
		board = new(SACK_LIMIT);
		counted = 0;
		burst_left = 5;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_header(4'b0000, 16'h0000, 8'h00, 32'h0, 32'h0, 3'd0);
		send_header(4'b0001, 16'hFFFF, 8'h00, 32'h0, 32'h0, 3'd0);
		send_header(4'b0001, 16'h0000, 8'h00, 32'h0, 32'h0, 3'd0);
		send_header(4'b0010, 16'h0000, 8'hFF, 32'h0, 32'h0, 3'd0);
		send_header(4'b0010, 16'h0000, 8'h00, 32'h0, 32'h0, 3'd0);
		send_header(4'b0100, 16'h0000, 8'h00, 32'h0, 32'h0, 3'd0);
		send_header(4'b1000, 16'h0000, 8'h00, 32'hFFFFFFFF, 32'h0, 3'd0);
		send_header(4'b1111, 16'h1234, 8'h0E, 32'h0, 32'hFFFFFFFF, 3'd0);
		send_block(32'hFFFFFFFF, 32'hFFFFFFFF);
		send_header(4'b1111, 16'hFFFF, 8'hFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 3'd3);
		send_block(32'hFFFFFFFF, 32'h00000000);
		send_block(32'h00000000, 32'hFFFFFFFF);
		send_block(32'h80000001, 32'h7FFFFFFE);
		send_header(4'b0000, 16'h0000, 8'h00, 32'h0, 32'h0, 3'd4);
		send_block(32'h01020304, 32'h05060708);
		send_block(32'h11223344, 32'h55667788);
		send_block(32'hA5A5A5A5, 32'h5A5A5A5A);
		send_header(4'b0101, 16'h05B4, 8'h00, 32'h0, 32'h0, 3'd2);
		send_block(32'hDEADBEEF, 32'h00C0FFEE);
		send_header(4'b0010, 16'h0000, 8'h07, 32'h0, 32'h0, 3'd0);
		send_header(4'b0000, 16'h0000, 8'h00, 32'h0, 32'h0, 3'd1);
		send_block(32'h00000000, 32'h00000000);

		target = counted + RANDOM_ITEMS;
		while (counted < target) begin
			case ($urandom_range(0, 9))
				0: send_item(tos_pkg::OP_BLOCK, scrambled_item());
				1: begin
					it = scrambled_item();
					it.mss_present = 1'b0;
					it.wscale_present = 1'b0;
					it.sack_permitted_present = 1'b0;
					it.timestamp_present = 1'b0;
					send_item(tos_pkg::OP_HEADER, it);
				end
				default: begin
					it = scrambled_item();
					if ($urandom_range(0, 1) == 0)
						it.sack_count = 3'd0;
					send_item(tos_pkg::OP_HEADER, it);
					n = (int'(it.sack_count) > SACK_LIMIT) ? SACK_LIMIT : int'(it.sack_count);
					if (n > 0 && $urandom_range(0, 9) == 0)
						n = $urandom_range(0, n - 1);
					repeat (n) send_item(tos_pkg::OP_BLOCK, scrambled_item());
				end
			endcase
		end
		s_tvalid <= 1'b0;

		while (board.area_bytes.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("sent %0d header requests, %0d sack block requests, %0d stray blocks",
			board.headers_seen, board.blocks_seen, board.ignored_seen);
		$display("checked %0d option bytes in %0d closed option areas",
			board.bytes_checked, board.areas_closed);
		if (board.errors == 0 && board.area_bytes.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("%0d mismatches, %0d bytes never seen",
				board.errors, board.area_bytes.size());
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule
